/* hdl/pfvc_pkg.sv */
// Package for the polygon fan volume and centroid core.
// Holds widths, the controller state type and the command/status structs.
package pfvc_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned CentW    = 14;
  localparam int unsigned VolW     = 43;
  localparam int unsigned WsumW    = 56;
  localparam int unsigned QuotW    = 56;
  localparam int unsigned DivStepW = 6;
  localparam int unsigned ProdW    = 26;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_TRIP,
    ST_WSUM,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_NEXT,
    ST_OUT
  } pfvc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_vertex;
    logic       store_first;
    logic       mul1;
    logic       mul2;
    logic       trip;
    logic       wsum;
    logic       div_init;
    logic       div_step;
    logic [1:0] div_axis;
    logic       div_save;
    logic       clear;
  } pfvc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic vol_zero;
    logic div_done;
  } pfvc_stat_t;

endpackage

/* hdl/polygon_fan_volume_centroid_core.sv */
// Top level of the polygon fan volume and centroid core.
// Joins pfvc_ctrl and pfvc_dp; depends on pfvc_pkg.
//
//   Channel | Handshake            | Beat
//   vertex  | in_valid_i/in_stall_o  | vertex_x/y/z_i, last_vertex_i
//   result  | out_valid_o/out_stall_i| centroid_x4/y4/z4_o, six_volume_o, zero_volume_o
//
// A vertex that closes a triangle runs the minor products, their differences,
// the triple product and the accumulation; the first two vertices are only
// loaded. The last vertex adds set-up, 56 steps of the shared bit-serial divider
// and a turnaround per axis, and the result load; zero volume skips the divider.
// Reset clears the facet state. A stalled result is held while the next facet
// is taken in; a new result waits until the old beat has left.
module polygon_fan_volume_centroid_core #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pfvc_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [pfvc_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [pfvc_pkg::CoordW-1:0] vertex_z_i,
  input  logic                               last_vertex_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pfvc_pkg::CentW-1:0]  centroid_x4_o,
  output logic signed [pfvc_pkg::CentW-1:0]  centroid_y4_o,
  output logic signed [pfvc_pkg::CentW-1:0]  centroid_z4_o,
  output logic signed [pfvc_pkg::VolW-1:0]   six_volume_o,
  output logic                               zero_volume_o
);
  import pfvc_pkg::*;

  pfvc_cmd_t  cmd;
  pfvc_stat_t stat;

  // Sequencer.
  pfvc_ctrl #(.MaxVertices(MAX_VERTICES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .last_vertex_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .stat_i(stat)
  );

  // Arithmetic.
  pfvc_dp #(.CoordBits(COORD_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .vertex_x_i, .vertex_y_i, .vertex_z_i,
    .centroid_x4_o, .centroid_y4_o, .centroid_z4_o,
    .six_volume_o, .zero_volume_o
  );

endmodule

/* hdl/pfvc_ctrl.sv */
// Controller state machine of the polygon fan volume and centroid core.
// Depends on pfvc_pkg for the state type and command/status structs.
module pfvc_ctrl #(
  parameter int unsigned MaxVertices = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 last_vertex_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pfvc_pkg::pfvc_cmd_t  cmd_o,
  input  pfvc_pkg::pfvc_stat_t stat_i
);
  import pfvc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxVertices + 1);

  pfvc_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic last_q, last_d;
  logic [1:0] axis_q, axis_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic take;

  assign accept = in_valid_i && !in_stall_o;
  assign take   = cnt_q < CntW'(MaxVertices);

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = last_vertex_i;
          if (take) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (take && cnt_q >= CntW'(2)) begin
            state_d = ST_MUL1;
          end else if (last_vertex_i) begin
            state_d = ST_DIV_INIT;
          end
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_TRIP;
      ST_TRIP: state_d = ST_WSUM;
      ST_WSUM: state_d = last_q ? ST_DIV_INIT : ST_IDLE;
      ST_DIV_INIT: begin
        axis_d  = 2'd0;
        state_d = stat_i.vol_zero ? ST_OUT : ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (stat_i.div_done) begin
          state_d = ST_DIV_NEXT;
        end
      end
      ST_DIV_NEXT: begin
        if (axis_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_DIV_RUN;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          cnt_d       = '0;
          axis_d      = 2'd0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs. The set-up in ST_DIV_NEXT loads the axis that runs next.
  always_comb begin
    cmd_o             = '0;
    cmd_o.div_axis    = (state_q == ST_DIV_NEXT) ? axis_q + 2'd1 : axis_q;
    in_stall_o        = (state_q != ST_IDLE);
    cmd_o.load_vertex = (state_q == ST_IDLE) && accept && take;
    cmd_o.store_first = cmd_o.load_vertex && (cnt_q == '0);
    cmd_o.mul1        = (state_q == ST_MUL1);
    cmd_o.mul2        = (state_q == ST_MUL2);
    cmd_o.trip        = (state_q == ST_TRIP);
    cmd_o.wsum        = (state_q == ST_WSUM);
    cmd_o.div_init    = (state_q == ST_DIV_INIT) ||
                        ((state_q == ST_DIV_NEXT) && (axis_q != 2'd2));
    cmd_o.div_step    = (state_q == ST_DIV_RUN);
    cmd_o.div_save    = (state_q == ST_DIV_RUN) && stat_i.div_done;
    cmd_o.clear       = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  assign out_valid_o = out_valid_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      axis_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/pfvc_dp.sv */
// Datapath of the polygon fan volume and centroid core: products, sums,
// and a restoring divider shared by the three axes. Depends on pfvc_pkg.
module pfvc_dp #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pfvc_pkg::pfvc_cmd_t                cmd_i,
  output pfvc_pkg::pfvc_stat_t               stat_o,
  input  logic signed [pfvc_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [pfvc_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [pfvc_pkg::CoordW-1:0] vertex_z_i,
  output logic signed [pfvc_pkg::CentW-1:0]  centroid_x4_o,
  output logic signed [pfvc_pkg::CentW-1:0]  centroid_y4_o,
  output logic signed [pfvc_pkg::CentW-1:0]  centroid_z4_o,
  output logic signed [pfvc_pkg::VolW-1:0]   six_volume_o,
  output logic                               zero_volume_o
);
  import pfvc_pkg::*;

  typedef logic signed [CoordW-1:0] crd_t;

  crd_t a_q[3], b_q[3], c_q[3];
  crd_t in_c[3];
  logic signed [ProdW-1:0] m_q[3], n_q[3];
  logic signed [VolW-1:0]  t_q, vol_q;
  logic signed [WsumW-1:0] ws_q[3];
  logic signed [CentW-1:0] cen_q[3];
  logic signed [CentW-1:0] cen_sel;
  logic                    zero_q;

  // Low CoordBits bits of each coordinate, sign-extended.
  always_comb begin
    in_c[0] = crd_t'(signed'(vertex_x_i[CoordBits-1:0]));
    in_c[1] = crd_t'(signed'(vertex_y_i[CoordBits-1:0]));
    in_c[2] = crd_t'(signed'(vertex_z_i[CoordBits-1:0]));
  end

  // Vertex registers: a is the first, b the previous, c the current.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vertex) begin
      for (int i = 0; i < 3; i++) begin
        b_q[i] <= c_q[i];
        c_q[i] <= in_c[i];
        if (cmd_i.store_first) begin
          a_q[i] <= in_c[i];
        end
      end
    end
  end

  // Minor products: m holds yz terms, n the subtracted yz terms.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      m_q[0] <= ProdW'(b_q[1] * c_q[2]);
      n_q[0] <= ProdW'(c_q[1] * b_q[2]);
      m_q[1] <= ProdW'(a_q[1] * c_q[2]);
      n_q[1] <= ProdW'(c_q[1] * a_q[2]);
      m_q[2] <= ProdW'(a_q[1] * b_q[2]);
      n_q[2] <= ProdW'(b_q[1] * a_q[2]);
    end else if (cmd_i.mul2) begin
      m_q[0] <= ProdW'(m_q[0] - n_q[0]);
      m_q[1] <= ProdW'(m_q[1] - n_q[1]);
      m_q[2] <= ProdW'(m_q[2] - n_q[2]);
    end
  end

  // Triple product of first, previous and current vertex.
  always_ff @(posedge clk_i) begin
    if (cmd_i.trip) begin
      t_q <= VolW'(a_q[0] * m_q[0]) - VolW'(b_q[0] * m_q[1])
           + VolW'(c_q[0] * m_q[2]);
    end
  end

  // Volume and weighted sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= '0;
      for (int i = 0; i < 3; i++) ws_q[i] <= '0;
    end else if (cmd_i.clear) begin
      vol_q <= '0;
      for (int i = 0; i < 3; i++) ws_q[i] <= '0;
    end else if (cmd_i.wsum) begin
      vol_q <= vol_q + t_q;
      for (int i = 0; i < 3; i++) begin
        ws_q[i] <= ws_q[i] + WsumW'((15'(a_q[i]) + 15'(b_q[i]) + 15'(c_q[i])) * t_q);
      end
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [QuotW-1:0]    dq_q;
  logic [VolW-1:0]     den_q;
  logic [VolW:0]       rem_q;
  logic [DivStepW-1:0] step_q;
  logic                neg_q;
  logic [VolW:0]       rem_sh;
  logic [VolW:0]       rem_sub;
  logic [QuotW-1:0]    qfin;
  logic signed [WsumW-1:0] num_sel;
  logic [WsumW-1:0]    num_mag;
  logic [VolW-1:0]     den_mag;

  assign num_sel = ws_q[cmd_i.div_axis];
  assign num_mag = num_sel[WsumW-1] ? WsumW'(-num_sel) : num_sel;
  assign den_mag = vol_q[VolW-1] ? VolW'(-vol_q) : vol_q;
  assign rem_sh  = {rem_q[VolW-1:0], dq_q[QuotW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign qfin    = {dq_q[QuotW-2:0], !rem_sub[VolW]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_init) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dq_q  <= num_mag;
      den_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_sel[WsumW-1] ^ vol_q[VolW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_sub[VolW] ? rem_sh : rem_sub;
      dq_q  <= qfin;
    end
  end

  assign stat_o.div_done = (step_q == DivStepW'(QuotW - 1));
  assign stat_o.vol_zero = (vol_q == '0);

  // Saturate the signed quotient to the centroid range.
  always_comb begin
    if (neg_q) begin
      cen_sel = (qfin > QuotW'(8192)) ? CentW'(-8192) : CentW'(-qfin);
    end else begin
      cen_sel = (qfin > QuotW'(8191)) ? CentW'(8191) : CentW'(qfin);
    end
  end

  // Result registers, loaded as each axis finishes and when the facet ends.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init && cmd_i.div_axis == 2'd0) begin
      for (int i = 0; i < 3; i++) cen_q[i] <= '0;
    end
    if (cmd_i.div_save) begin
      cen_q[cmd_i.div_axis] <= cen_sel;
    end
    if (cmd_i.clear) begin
      zero_q       <= stat_o.vol_zero;
      six_volume_o <= vol_q;
      centroid_x4_o <= cen_q[0];
      centroid_y4_o <= cen_q[1];
      centroid_z4_o <= cen_q[2];
    end
  end

  assign zero_volume_o = zero_q;

endmodule

/* verif/tb.sv */
// Testbench for polygon_fan_volume_centroid_core: random and directed facets.
// Depends on pfvc_pkg and the core; predicts volume and centroid per facet.
module tb;

  import pfvc_pkg::*;

  localparam int unsigned MaxVerts = 64;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     last;
  } vertex_t;

  typedef struct packed {
    logic signed [CentW-1:0] cx;
    logic signed [CentW-1:0] cy;
    logic signed [CentW-1:0] cz;
    logic signed [VolW-1:0]  vol;
    logic                    zero;
  } facet_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordW-1:0] vertex_x_i = '0;
  logic signed [CoordW-1:0] vertex_y_i = '0;
  logic signed [CoordW-1:0] vertex_z_i = '0;
  logic last_vertex_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CentW-1:0] centroid_x4_o, centroid_y4_o, centroid_z4_o;
  logic signed [VolW-1:0] six_volume_o;
  logic zero_volume_o;

  polygon_fan_volume_centroid_core dut (.*);

  always #5 clk_i = ~clk_i;

  vertex_t    pending_verts[$];
  facet_res_t expected_facets[$];
  int errors = 0;
  int facets_seen = 0;
  bit calm = 1'b0;
  bit hold_send = 1'b0;
  bit stim_done = 1'b0;

  // Predicted facet state.
  longint fp[3], pp[3], wsum[3];
  longint vsum;
  int vcount;

  function automatic longint cent_div(longint num, longint den);
    longint q;
    q = num / den;
    if (q > 8191) q = 8191;
    if (q < -8192) q = -8192;
    return q;
  endfunction

  // Update the facet accumulators with one vertex and queue any result.
  task automatic predict_vertex(vertex_t v);
    longint p[3];
    longint t, t1, t2, t3;
    facet_res_t r;
    p[0] = v.x; p[1] = v.y; p[2] = v.z;
    if (vcount < MaxVerts) begin
      if (vcount == 0) begin
        fp = p;
      end else if (vcount >= 2) begin
        t1 = pp[1] * p[2] - p[1] * pp[2];
        t2 = fp[1] * p[2] - p[1] * fp[2];
        t3 = fp[1] * pp[2] - pp[1] * fp[2];
        t = fp[0] * t1 - pp[0] * t2 + p[0] * t3;
        vsum += t;
        for (int i = 0; i < 3; i++) wsum[i] += (fp[i] + pp[i] + p[i]) * t;
      end
      pp = p;
      vcount++;
    end
    if (v.last) begin
      if (vsum == 0) begin
        r = '{cx: '0, cy: '0, cz: '0, vol: '0, zero: 1'b1};
      end else begin
        r.cx = CentW'(cent_div(wsum[0], vsum));
        r.cy = CentW'(cent_div(wsum[1], vsum));
        r.cz = CentW'(cent_div(wsum[2], vsum));
        r.vol = VolW'(vsum);
        r.zero = 1'b0;
      end
      expected_facets = {expected_facets, r};
      vcount = 0; vsum = 0;
      for (int i = 0; i < 3; i++) begin
        fp[i] = 0; pp[i] = 0; wsum[i] = 0;
      end
    end
  endtask

  // Driver: presents vertices with random idle bursts.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict_vertex({vertex_x_i, vertex_y_i, vertex_z_i, last_vertex_i});
    end
    if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 13);
        in_valid_i <= 1'b0;
      end else if (pending_verts.size() > 0 && !hold_send) begin
        vertex_t v;
        v = pending_verts.pop_front();
        in_valid_i <= 1'b1;
        vertex_x_i <= v.x;
        vertex_y_i <= v.y;
        vertex_z_i <= v.z;
        last_vertex_i <= v.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stall, in bursts.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_facets.size() == 0) begin
        $error("Result beat with nothing expected");
        errors++;
      end else begin
        facet_res_t e;
        e = expected_facets.pop_front();
        facets_seen++;
        if (centroid_x4_o !== e.cx) begin
          $error("centroid_x4 expected %0d got %0d", e.cx, centroid_x4_o); errors++;
        end
        if (centroid_y4_o !== e.cy) begin
          $error("centroid_y4 expected %0d got %0d", e.cy, centroid_y4_o); errors++;
        end
        if (centroid_z4_o !== e.cz) begin
          $error("centroid_z4 expected %0d got %0d", e.cz, centroid_z4_o); errors++;
        end
        if (six_volume_o !== e.vol) begin
          $error("six_volume expected %0d got %0d", e.vol, six_volume_o); errors++;
        end
        if (zero_volume_o !== e.zero) begin
          $error("zero_volume expected %0d got %0d", e.zero, zero_volume_o); errors++;
        end
      end
    end
  end

  task automatic add_vert(int x, int y, int z, bit last);
    vertex_t v;
    v.x = CoordW'(x); v.y = CoordW'(y); v.z = CoordW'(z); v.last = last;
    pending_verts = {pending_verts, v};
  endtask

  // One random facet of n vertices: full-range coordinates for a span of 2048, else within +-span.
  task automatic add_facet(int n, int span);
    for (int i = 0; i < n; i++) begin
      if (span >= 2048) begin
        add_vert($signed(12'($urandom)), $signed(12'($urandom)), $signed(12'($urandom)),
                 i == n - 1);
      end else begin
        add_vert($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                 $urandom_range(0, 2 * span) - span, i == n - 1);
      end
    end
  endtask

  initial begin
    int total;
    int n;
    for (int i = 0; i < 3; i++) begin
      fp[i] = 0; pp[i] = 0; wsum[i] = 0;
    end
    vsum = 0; vcount = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single and two-vertex facets, a flat facet, extremes.
    add_vert(5, 6, 7, 1'b1);
    add_vert(1, 2, 3, 1'b0); add_vert(-4, 9, 1, 1'b1);
    add_vert(0, 0, 0, 1'b0); add_vert(1, 0, 0, 1'b0); add_vert(0, 1, 0, 1'b1);
    add_vert(2047, 0, 0, 1'b0); add_vert(0, 2047, 0, 1'b0);
    add_vert(0, 0, 2047, 1'b1);
    add_vert(-2048, -2048, -2048, 1'b0); add_vert(2047, -2048, 2047, 1'b0);
    add_vert(-2048, 2047, 2047, 1'b0); add_vert(2047, 2047, -2048, 1'b1);
    // Tiny volume far from origin gives large centroid values.
    add_vert(2047, 2047, 2047, 1'b0); add_vert(2046, 2047, 2047, 1'b0);
    add_vert(2047, 2046, 2047, 1'b1);
    add_vert(-2048, -2048, -2048, 1'b0); add_vert(-2047, -2048, -2048, 1'b0);
    add_vert(-2048, -2047, -2048, 1'b1);
    // Over-long facet: the vertices past the limit are dropped.
    add_facet(70, 2048);

    // Pause the sender until all pending results are back.
    wait (pending_verts.size() == 0);
    hold_send = 1'b1;
    wait (expected_facets.size() == 0 && !in_valid_i);
    repeat (20) @(posedge clk_i);
    hold_send = 1'b0;

    total = 0;
    while (total < 1750) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(1, 2);
        1: n = $urandom_range(60, 68);
        default: n = $urandom_range(3, 12);
      endcase
      add_facet(n, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 2048);
      total += n;
      if (total > 1500) calm = 1'b1;
      wait (pending_verts.size() < 40);
    end
    wait (pending_verts.size() == 0);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (expected_facets.size() == 0 && !in_valid_i);
    repeat (400) @(posedge clk_i);
    $display("Checked %0d facet results over about 1750 vertices,", facets_seen);
    $display("including short, flat, saturating and over-long facets.");
    if (errors == 0 && expected_facets.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
